// ----- hdl/fpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the page allocator
// Command codes, result status codes, field widths, defaults and the
// reset pattern of one free-map word.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned CmdW       = 3;
  localparam int unsigned PageFieldW = 10;
  localparam int unsigned LinkW      = 11;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned PagesOutW  = 11;
  localparam int unsigned BytesW     = 23;
  localparam int unsigned MapWordW   = 32;
  localparam int unsigned MapBitW    = 5;

  localparam int unsigned DefNumPages      = 1024;
  localparam int unsigned DefPageBytes     = 4096;
  localparam int unsigned DefReservedPages = 8;

  localparam logic signed [LinkW-1:0] EndLink = -11'sd1;

  localparam logic [StatusW-1:0] StatusOk     = 2'd0;
  localparam logic [StatusW-1:0] StatusNoFree = 2'd1;
  localparam logic [StatusW-1:0] StatusCycle  = 2'd2;

  typedef enum logic [CmdW-1:0] {
    CmdAlloc     = 3'd0,
    CmdFreeChain = 3'd1,
    CmdWriteLink = 3'd2,
    CmdReadEntry = 3'd3,
    CmdMarkPage  = 3'd4,
    CmdChainLen  = 3'd5
  } fpa_cmd_e;

  typedef struct packed {
    logic link_re;
    logic link_we;
    logic map_re;
    logic map_we;
  } fpa_mem_ctl_t;

  function automatic logic [MapWordW-1:0] fpa_reset_word(input int unsigned word,
                                                         input int unsigned reserved,
                                                         input int unsigned num);
    logic [MapWordW-1:0] w;
    int unsigned         p;
    w = '0;
    for (int unsigned b = 0; b < MapWordW; b++) begin
      p    = (word << MapBitW) + b;
      w[b] = (p >= reserved) && (p < num);
    end
    return w;
  endfunction

endpackage

// ----- hdl/fpa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_if: command and response channels of the page allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fpa_cmd_if;
  import fpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          command;
  logic [PageFieldW-1:0]    page;
  logic signed [LinkW-1:0]  link_value;
  logic                     mark_free;

  modport source (output valid, command, page, link_value, mark_free, input ready);
  modport sink   (input valid, command, page, link_value, mark_free, output ready);
endinterface

interface fpa_rsp_if;
  import fpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic signed [LinkW-1:0]  page_out;
  logic                     page_free;
  logic [PagesOutW-1:0]     chain_pages;
  logic [BytesW-1:0]        chain_bytes;

  modport source (output valid, status, page_out, page_free, chain_pages, chain_bytes,
                  input ready);
  modport sink   (input valid, status, page_out, page_free, chain_pages, chain_bytes,
                  output ready);
endinterface

// ----- hdl/fat_page_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_page_allocator_core: page allocator with free bitmap and link table
// Steps: write link writes the link table; read entry reads both memories;
//   mark page reads then rewrites a free-map word; allocate checks one word at
//   a time; free chain reads and rewrites each link, chain length only reads it.
// Throughput: one command at a time; the next is taken once the result sits
//   in the output register.
// Reset: a clearing pass over every page index rebuilds both memories; no
//   command is taken during it.
// ----------------------------------------------------------------------------
module fat_page_allocator_core #(
  parameter int unsigned NUM_PAGES      = fpa_pkg::DefNumPages,
  parameter int unsigned PAGE_BYTES     = fpa_pkg::DefPageBytes,
  parameter int unsigned RESERVED_PAGES = fpa_pkg::DefReservedPages
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_cmd_if.sink   cmd_i,
  fpa_rsp_if.source rsp_o
);
  import fpa_pkg::*;

  localparam int unsigned PageW    = $clog2(NUM_PAGES);
  localparam int unsigned NumWords = (NUM_PAGES + MapWordW - 1) / MapWordW;
  localparam int unsigned WordIdxW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned CntW     = $clog2(NUM_PAGES + 1);

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StDispatch,
    StAllocRd,
    StAllocChk,
    StWalkRd,
    StWalkWr,
    StEntryWait,
    StMarkWr,
    StResp
  } state_e;

  state_e                  state_q, state_d;
  logic [PageW-1:0]        clr_q, clr_d;
  logic [CmdW-1:0]         cmd_q, cmd_d;
  logic signed [LinkW-1:0] cur_q, cur_d;
  logic signed [LinkW-1:0] link_q, link_d;
  logic                    mark_q, mark_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [WordIdxW-1:0]     scan_q, scan_d;
  logic [StatusW-1:0]      st_status_q, st_status_d;
  logic signed [LinkW-1:0] st_page_q, st_page_d;
  logic                    st_free_q, st_free_d;

  logic                    rsp_valid_q, rsp_valid_d;
  logic [StatusW-1:0]      rsp_status_q, rsp_status_d;
  logic signed [LinkW-1:0] rsp_page_q, rsp_page_d;
  logic                    rsp_free_q, rsp_free_d;
  logic [PagesOutW-1:0]    rsp_pages_q, rsp_pages_d;
  logic [BytesW-1:0]       rsp_bytes_q, rsp_bytes_d;

  fpa_mem_ctl_t            mem_ctl;
  logic [PageW-1:0]        link_addr;
  logic signed [LinkW-1:0] link_wdata;
  logic signed [LinkW-1:0] link_rdata;
  logic [WordIdxW-1:0]     map_addr;
  logic [MapWordW-1:0]     map_wdata;
  logic [MapWordW-1:0]     map_rdata;

  logic                    find_hit;
  logic [MapBitW-1:0]      find_bit;

  logic [PageFieldW-1:0]   cur_page;
  logic [PageW-1:0]        cur_addr;
  logic [WordIdxW-1:0]     cur_word;
  logic [MapWordW-1:0]     cur_mask;
  logic                    cur_in_range;
  logic                    releasing;
  logic                    out_free;

  assign cur_page     = cur_q[PageFieldW-1:0];
  assign cur_addr     = PageW'(cur_page);
  assign cur_word     = WordIdxW'(cur_page >> MapBitW);
  assign cur_mask     = MapWordW'(1) << cur_page[MapBitW-1:0];
  assign cur_in_range = !cur_q[LinkW-1] && (32'(cur_page) < NUM_PAGES);
  assign releasing    = (cmd_q == CmdFreeChain);
  assign out_free     = !rsp_valid_q || rsp_o.ready;

  fpa_store #(
    .NumPages (NUM_PAGES),
    .NumWords (NumWords),
    .PageW    (PageW),
    .WordIdxW (WordIdxW)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .link_addr_i  (link_addr),
    .link_wdata_i (link_wdata),
    .link_rdata_o (link_rdata),
    .map_addr_i   (map_addr),
    .map_wdata_i  (map_wdata),
    .map_rdata_o  (map_rdata)
  );

  fpa_find u_find (
    .word_i  (map_rdata),
    .found_o (find_hit),
    .bit_o   (find_bit)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    link_d      = link_q;
    mark_d      = mark_q;
    count_d     = count_q;
    scan_d      = scan_q;
    st_status_d = st_status_q;
    st_page_d   = st_page_q;
    st_free_d   = st_free_q;

    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_page_d   = rsp_page_q;
    rsp_free_d   = rsp_free_q;
    rsp_pages_d  = rsp_pages_q;
    rsp_bytes_d  = rsp_bytes_q;

    mem_ctl    = '0;
    link_addr  = cur_addr;
    link_wdata = EndLink;
    map_addr   = cur_word;
    map_wdata  = map_rdata | cur_mask;

    unique case (state_q)
      StClear: begin
        mem_ctl.link_we = 1'b1;
        link_addr       = clr_q;
        map_addr        = WordIdxW'(clr_q);
        map_wdata       = fpa_reset_word(32'(clr_q), RESERVED_PAGES, NUM_PAGES);
        mem_ctl.map_we  = (32'(clr_q) < NumWords);
        clr_d           = clr_q + PageW'(1);
        if (clr_q == PageW'(NUM_PAGES - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (cmd_i.valid) begin
          cmd_d       = cmd_i.command;
          cur_d       = LinkW'({1'b0, cmd_i.page});
          link_d      = cmd_i.link_value;
          mark_d      = cmd_i.mark_free;
          count_d     = '0;
          scan_d      = '0;
          st_status_d = StatusOk;
          st_page_d   = EndLink;
          st_free_d   = 1'b0;
          state_d     = StDispatch;
        end
      end
      StDispatch: begin
        state_d = StResp;
        unique case (cmd_q)
          CmdAlloc: state_d = StAllocRd;
          CmdFreeChain, CmdChainLen: state_d = StWalkRd;
          CmdWriteLink: begin
            mem_ctl.link_we = cur_in_range;
            link_wdata      = link_q[LinkW-1] ? EndLink : link_q;
          end
          CmdReadEntry: begin
            if (cur_in_range) begin
              mem_ctl.link_re = 1'b1;
              mem_ctl.map_re  = 1'b1;
              state_d         = StEntryWait;
            end
          end
          CmdMarkPage: begin
            if (cur_in_range) begin
              mem_ctl.map_re = 1'b1;
              state_d        = StMarkWr;
            end
          end
          default: state_d = StResp;
        endcase
      end
      StAllocRd: begin
        mem_ctl.map_re = 1'b1;
        map_addr       = scan_q;
        state_d        = StAllocChk;
      end
      StAllocChk: begin
        map_addr = scan_q;
        if (find_hit) begin
          mem_ctl.map_we = 1'b1;
          map_wdata      = map_rdata & ~(MapWordW'(1) << find_bit);
          st_page_d      = LinkW'({scan_q, find_bit});
          state_d        = StResp;
        end else if (scan_q == WordIdxW'(NumWords - 1)) begin
          st_status_d = StatusNoFree;
          state_d     = StResp;
        end else begin
          scan_d  = scan_q + WordIdxW'(1);
          state_d = StAllocRd;
        end
      end
      StWalkRd: begin
        if (!cur_in_range) begin
          state_d = StResp;
        end else if (32'(count_q) >= NUM_PAGES) begin
          st_status_d = StatusCycle;
          state_d     = StResp;
        end else begin
          mem_ctl.link_re = 1'b1;
          mem_ctl.map_re  = releasing;
          state_d         = StWalkWr;
        end
      end
      StWalkWr: begin
        mem_ctl.link_we = releasing;
        mem_ctl.map_we  = releasing;
        count_d         = count_q + CntW'(1);
        cur_d           = link_rdata;
        state_d         = StWalkRd;
      end
      StEntryWait: begin
        st_page_d = link_rdata;
        st_free_d = |(map_rdata & cur_mask);
        state_d   = StResp;
      end
      StMarkWr: begin
        mem_ctl.map_we = 1'b1;
        map_wdata      = mark_q ? (map_rdata | cur_mask) : (map_rdata & ~cur_mask);
        state_d        = StResp;
      end
      StResp: begin
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = st_status_q;
          rsp_page_d   = st_page_q;
          rsp_free_d   = st_free_q;
          rsp_pages_d  = PagesOutW'(count_q);
          rsp_bytes_d  = (cmd_q == CmdChainLen) ?
                         BytesW'(32'(count_q) * PAGE_BYTES) : '0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_q        <= '0;
      cmd_q        <= '0;
      cur_q        <= EndLink;
      link_q       <= EndLink;
      mark_q       <= 1'b0;
      count_q      <= '0;
      scan_q       <= '0;
      st_status_q  <= StatusOk;
      st_page_q    <= EndLink;
      st_free_q    <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= StatusOk;
      rsp_page_q   <= EndLink;
      rsp_free_q   <= 1'b0;
      rsp_pages_q  <= '0;
      rsp_bytes_q  <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cmd_q        <= cmd_d;
      cur_q        <= cur_d;
      link_q       <= link_d;
      mark_q       <= mark_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      st_status_q  <= st_status_d;
      st_page_q    <= st_page_d;
      st_free_q    <= st_free_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_status_q <= rsp_status_d;
      rsp_page_q   <= rsp_page_d;
      rsp_free_q   <= rsp_free_d;
      rsp_pages_q  <= rsp_pages_d;
      rsp_bytes_q  <= rsp_bytes_d;
    end
  end

  assign cmd_i.ready       = (state_q == StIdle);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.page_out    = rsp_page_q;
  assign rsp_o.page_free   = rsp_free_q;
  assign rsp_o.chain_pages = rsp_pages_q;
  assign rsp_o.chain_bytes = rsp_bytes_q;

endmodule

// ----- hdl/fpa_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_store: link table and free-map memories
// One link per page and one free-map word per 32 pages, each with a single
// port, synchronous write and registered read data.
// ----------------------------------------------------------------------------
module fpa_store #(
  parameter int unsigned NumPages = fpa_pkg::DefNumPages,
  parameter int unsigned NumWords = 32,
  parameter int unsigned PageW    = 10,
  parameter int unsigned WordIdxW = 5
) (
  input  logic                              clk_i,
  input  fpa_pkg::fpa_mem_ctl_t             ctl_i,
  input  logic [PageW-1:0]                  link_addr_i,
  input  logic signed [fpa_pkg::LinkW-1:0]  link_wdata_i,
  output logic signed [fpa_pkg::LinkW-1:0]  link_rdata_o,
  input  logic [WordIdxW-1:0]               map_addr_i,
  input  logic [fpa_pkg::MapWordW-1:0]      map_wdata_i,
  output logic [fpa_pkg::MapWordW-1:0]      map_rdata_o
);
  import fpa_pkg::*;

  logic signed [LinkW-1:0] link_mem [NumPages];
  logic [MapWordW-1:0]     map_mem  [NumWords];

  always_ff @(posedge clk_i) begin
    if (ctl_i.link_we) begin
      link_mem[link_addr_i] <= link_wdata_i;
    end
    if (ctl_i.link_re) begin
      link_rdata_o <= link_mem[link_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.map_we) begin
      map_mem[map_addr_i] <= map_wdata_i;
    end
    if (ctl_i.map_re) begin
      map_rdata_o <= map_mem[map_addr_i];
    end
  end

endmodule

// ----- hdl/fpa_find.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_find: lowest free page within one free-map word
// Priority encoder over a 32-bit word, lowest set bit wins.
// ----------------------------------------------------------------------------
module fpa_find (
  input  logic [fpa_pkg::MapWordW-1:0] word_i,
  output logic                         found_o,
  output logic [fpa_pkg::MapBitW-1:0]  bit_o
);
  import fpa_pkg::*;

  always_comb begin
    found_o = |word_i;
    bit_o   = '0;
    for (int i = MapWordW - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        bit_o = MapBitW'(i);
      end
    end
  end

endmodule

// ----- hdl/fpa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_checker: response port checks for the page allocator
// Watches the response channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module fpa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [fpa_pkg::StatusW-1:0]       rsp_status_i,
  input logic signed [fpa_pkg::LinkW-1:0]  rsp_page_i,
  input logic                              rsp_free_i,
  input logic [fpa_pkg::PagesOutW-1:0]     rsp_pages_i,
  input logic [fpa_pkg::BytesW-1:0]        rsp_bytes_i
);
  import fpa_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response beat dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_page_i) && $stable(rsp_pages_i))
    else $error("response payload changed while stalled");

  a_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == StatusNoFree) |->
      (rsp_page_i == EndLink) && (rsp_pages_i == '0) && !rsp_free_i)
    else $error("failed allocate returned a page");

  a_free_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_free_i |->
      (rsp_status_i == StatusOk) && (rsp_pages_i == '0) && (rsp_bytes_i == '0))
    else $error("free bit reported outside read entry");

  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_bytes_i != '0) |->
      (rsp_pages_i != '0) && (rsp_page_i == EndLink))
    else $error("byte count without page count");

endmodule

bind fat_page_allocator_core fpa_checker u_fpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_page_i   (rsp_o.page_out),
  .rsp_free_i   (rsp_o.page_free),
  .rsp_pages_i  (rsp_o.chain_pages),
  .rsp_bytes_i  (rsp_o.chain_bytes)
);
